@@ hw/rtl/indexed_min_heap_open_list_core_defines.svh @@
// ---------------------------------------------------------------------------
// indexed_min_heap_open_list_core_defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_OPEN_LIST_CORE_DEFINES_SVH
`define INDEXED_MIN_HEAP_OPEN_LIST_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define IMHOL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heap core check failed");

// next-cycle implication
`define IMHOL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heap core check failed");

`endif

@@ hw/rtl/imhol_pkg.sv @@
// ---------------------------------------------------------------------------
// imhol_pkg
// types and constants of the indexed min-heap open list
// ---------------------------------------------------------------------------
`default_nettype none

package imhol_pkg;

	localparam int X_BITS     = 6;
	localparam int Y_BITS     = 6;
	localparam int CELL_BITS  = X_BITS + Y_BITS;
	localparam int CELL_COUNT = 1 << CELL_BITS;
	localparam int KEY_BITS   = 32;
	localparam int HEAP_DEPTH = 4096;
	localparam int IDX_BITS   = $clog2(HEAP_DEPTH);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int STAT_BITS  = 2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [STAT_BITS-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_PRESENT = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [CELL_BITS-1:0] loc;
	} entry_t;

	typedef struct packed {
		logic                present;
		logic [IDX_BITS-1:0] idx;
	} pmap_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_INS_CHK,
		S_SU_RD,
		S_SU_CMP,
		S_EX_ROOT,
		S_EX_LAST,
		S_SD_RL,
		S_SD_RR,
		S_SD_CMP,
		S_PLACE,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/indexed_min_heap_open_list_core.sv @@
// ---------------------------------------------------------------------------
// indexed_min_heap_open_list_core
// binary min-heap of grid cells with a position map and decrease-key
// ---------------------------------------------------------------------------
// One command at a time: a transfer happens when start is high and busy is
// low, and exactly one result follows, shown for one cycle with done high.
// The receiver cannot stall, so results must be taken when done pulses.
// After reset the position map is swept to absent, one entry a cycle, so
// busy stays high until all 4096 entries are clear. An insert climbs from
// its slot toward the root, moving each larger parent down a level. An
// extract on an empty heap reports empty; else it takes the root out and,
// if entries remain, moves the last entry to the root and sifts it down,
// the smaller child moving up, until it settles. The block returns to idle
// after each done. The heap memory, read once per cycle, has a registered
// read port.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_open_list_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              operation,
	input  wire logic [imhol_pkg::X_BITS-1:0]      cell_x,
	input  wire logic [imhol_pkg::Y_BITS-1:0]      cell_y,
	input  wire logic [imhol_pkg::KEY_BITS-1:0]    new_key,
	output logic                                   done,
	output logic [imhol_pkg::X_BITS-1:0]           out_x,
	output logic [imhol_pkg::Y_BITS-1:0]           out_y,
	output logic [imhol_pkg::KEY_BITS-1:0]         out_key,
	output logic [imhol_pkg::STAT_BITS-1:0]        status,
	output logic [imhol_pkg::CNT_BITS-1:0]         heap_size
);

	localparam int IB = imhol_pkg::IDX_BITS;
	localparam int CB = imhol_pkg::CNT_BITS;

	imhol_pkg::state_t state_q, state_d;

	// memories
	imhol_pkg::entry_t heap_mem [imhol_pkg::HEAP_DEPTH];
	imhol_pkg::pmap_t  pmap_mem [imhol_pkg::CELL_COUNT];

	logic                            hp_we;
	logic [IB-1:0]                   hp_waddr, hp_raddr;
	imhol_pkg::entry_t               hp_wdata, hp_rd_q;
	logic                            pm_we;
	logic [imhol_pkg::CELL_BITS-1:0] pm_waddr, pm_raddr;
	imhol_pkg::pmap_t                pm_wdata, pm_rd_q;

	// working registers
	logic [CB-1:0]                   count_q;
	logic [IB-1:0]                   pos_q;
	imhol_pkg::entry_t               item_q, lent_q;
	logic                            rv_q;
	logic [imhol_pkg::CELL_BITS-1:0] clr_q;
	logic [imhol_pkg::X_BITS-1:0]    out_x_q;
	logic [imhol_pkg::Y_BITS-1:0]    out_y_q;
	logic [imhol_pkg::KEY_BITS-1:0]  out_key_q;
	logic [imhol_pkg::STAT_BITS-1:0] status_q;

	// index arithmetic
	logic [IB-1:0] pos_m1, parent;
	logic [CB:0]   lidx, ridx;
	logic          l_ok, r_ok, lsel, rsel;
	logic [imhol_pkg::KEY_BITS-1:0] bestkey;

	assign pos_m1  = pos_q - IB'(1);
	assign parent  = {1'b0, pos_m1[IB-1:1]};
	assign lidx    = {1'b0, pos_q, 1'b1};
	assign ridx    = lidx + (CB+1)'(1);
	assign l_ok    = lidx < {1'b0, count_q};
	assign r_ok    = ridx < {1'b0, count_q};
	assign lsel    = item_q.key > lent_q.key;
	assign bestkey = lsel ? lent_q.key : item_q.key;
	assign rsel    = rv_q && (bestkey > hp_rd_q.key);

	always_ff @(posedge clk) begin
		if (hp_we) begin
			heap_mem[hp_waddr] <= hp_wdata;
		end
		hp_rd_q <= heap_mem[hp_raddr];
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			pmap_mem[pm_waddr] <= pm_wdata;
		end
		pm_rd_q <= pmap_mem[pm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imhol_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		hp_we    = 1'b0;
		hp_waddr = pos_q;
		hp_wdata = item_q;
		hp_raddr = parent;
		pm_we    = 1'b0;
		pm_waddr = item_q.loc;
		pm_wdata = '{present: 1'b1, idx: pos_q};
		pm_raddr = {cell_x, cell_y};
		unique case (state_q)
			imhol_pkg::S_CLR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
				if (&clr_q) begin
					state_d = imhol_pkg::S_IDLE;
				end
			end
			imhol_pkg::S_IDLE: begin
				hp_raddr = '0;
				if (start) begin
					if (operation == imhol_pkg::OP_INSERT) begin
						state_d = imhol_pkg::S_INS_CHK;
					end else if (count_q == '0) begin
						state_d = imhol_pkg::S_DONE;
					end else begin
						state_d = imhol_pkg::S_EX_ROOT;
					end
				end
			end
			imhol_pkg::S_INS_CHK: begin
				if (pm_rd_q.present || count_q < CB'(imhol_pkg::HEAP_DEPTH)) begin
					state_d = imhol_pkg::S_SU_RD;
				end else begin
					state_d = imhol_pkg::S_DONE;
				end
			end
			imhol_pkg::S_SU_RD: begin
				state_d = (pos_q == '0) ? imhol_pkg::S_PLACE : imhol_pkg::S_SU_CMP;
			end
			imhol_pkg::S_SU_CMP: begin
				if (hp_rd_q.key > item_q.key) begin
					// parent moves down into the hole
					hp_we    = 1'b1;
					hp_wdata = hp_rd_q;
					pm_we    = 1'b1;
					pm_waddr = hp_rd_q.loc;
					state_d  = imhol_pkg::S_SU_RD;
				end else begin
					state_d = imhol_pkg::S_PLACE;
				end
			end
			imhol_pkg::S_EX_ROOT: begin
				hp_raddr = count_q[IB-1:0] - IB'(1);
				pm_we    = 1'b1;
				pm_waddr = hp_rd_q.loc;
				pm_wdata = '0;
				state_d  = imhol_pkg::S_EX_LAST;
			end
			imhol_pkg::S_EX_LAST: begin
				state_d = (count_q == '0) ? imhol_pkg::S_DONE : imhol_pkg::S_SD_RL;
			end
			imhol_pkg::S_SD_RL: begin
				hp_raddr = lidx[IB-1:0];
				state_d  = l_ok ? imhol_pkg::S_SD_RR : imhol_pkg::S_PLACE;
			end
			imhol_pkg::S_SD_RR: begin
				hp_raddr = ridx[IB-1:0];
				state_d  = imhol_pkg::S_SD_CMP;
			end
			imhol_pkg::S_SD_CMP: begin
				if (rsel || lsel) begin
					// smaller child moves up into the hole, left wins ties
					hp_we    = 1'b1;
					hp_wdata = rsel ? hp_rd_q : lent_q;
					pm_we    = 1'b1;
					pm_waddr = hp_wdata.loc;
					state_d  = imhol_pkg::S_SD_RL;
				end else begin
					state_d = imhol_pkg::S_PLACE;
				end
			end
			imhol_pkg::S_PLACE: begin
				hp_we   = 1'b1;
				pm_we   = 1'b1;
				state_d = imhol_pkg::S_DONE;
			end
			imhol_pkg::S_DONE: begin
				state_d = imhol_pkg::S_IDLE;
			end
			default: begin
				state_d = imhol_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (state_q == imhol_pkg::S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == imhol_pkg::S_INS_CHK && !pm_rd_q.present &&
			    count_q < CB'(imhol_pkg::HEAP_DEPTH)) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == imhol_pkg::S_EX_ROOT) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			imhol_pkg::S_IDLE: begin
				item_q    <= '{key: new_key, loc: {cell_x, cell_y}};
				out_x_q   <= '0;
				out_y_q   <= '0;
				out_key_q <= '0;
				status_q  <= (operation == imhol_pkg::OP_EXTRACT && count_q == '0) ?
				             imhol_pkg::ST_EMPTY : imhol_pkg::ST_DONE;
			end
			imhol_pkg::S_INS_CHK: begin
				if (pm_rd_q.present) begin
					pos_q    <= pm_rd_q.idx;
					status_q <= imhol_pkg::ST_PRESENT;
				end else begin
					pos_q <= count_q[IB-1:0];
				end
			end
			imhol_pkg::S_SU_CMP: begin
				if (hp_rd_q.key > item_q.key) begin
					pos_q <= parent;
				end
			end
			imhol_pkg::S_EX_ROOT: begin
				out_x_q   <= hp_rd_q.loc[imhol_pkg::CELL_BITS-1:imhol_pkg::Y_BITS];
				out_y_q   <= hp_rd_q.loc[imhol_pkg::Y_BITS-1:0];
				out_key_q <= hp_rd_q.key;
			end
			imhol_pkg::S_EX_LAST: begin
				item_q <= hp_rd_q;
				pos_q  <= '0;
			end
			imhol_pkg::S_SD_RL: begin
				rv_q <= r_ok;
			end
			imhol_pkg::S_SD_RR: begin
				lent_q <= hp_rd_q;
			end
			imhol_pkg::S_SD_CMP: begin
				if (rsel) begin
					pos_q <= ridx[IB-1:0];
				end else if (lsel) begin
					pos_q <= lidx[IB-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = state_q != imhol_pkg::S_IDLE;
	assign done      = state_q == imhol_pkg::S_DONE;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_key   = out_key_q;
	assign status    = status_q;
	assign heap_size = count_q;

endmodule

`default_nettype wire

@@ hw/rtl/imhol_checker.sv @@
// ---------------------------------------------------------------------------
// imhol_checker
// port-level checks of the heap core, bound to the core module
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_min_heap_open_list_core_defines.svh"

module imhol_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic                               done,
	input wire logic [imhol_pkg::X_BITS-1:0]       out_x,
	input wire logic [imhol_pkg::Y_BITS-1:0]       out_y,
	input wire logic [imhol_pkg::KEY_BITS-1:0]     out_key,
	input wire logic [imhol_pkg::STAT_BITS-1:0]    status,
	input wire logic [imhol_pkg::CNT_BITS-1:0]     heap_size
);

	logic empty_clean;

	assign empty_clean = heap_size == '0 && out_key == '0 && out_x == '0 && out_y == '0;

	// a transfer always leads to work in progress
	`IMHOL_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// a result is a single-cycle strobe and frees the block
	`IMHOL_ASSERT_NEXT(a_done_frees, done, !done && !busy)
	// an empty report leaves nothing in the heap and carries no cell
	`IMHOL_ASSERT_NOW(a_empty_zero, done && status == imhol_pkg::ST_EMPTY, empty_clean)
	// result only while the block is busy
	`IMHOL_ASSERT_NOW(a_done_busy, done, busy)

endmodule

bind indexed_min_heap_open_list_core imhol_checker u_imhol_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// regression for the indexed min-heap open list core
// ---------------------------------------------------------------------------
// Drives insert and extract commands through the start/busy handshake,
// with random gaps between them. A scoreboard keeps its own copy of the
// heap and position map, predicts each result, and compares it field by
// field when done pulses. The run opens with directed corner cases and
// then moves on to random traffic in grow, drain and mixed phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

import imhol_pkg::*;

typedef struct {
	logic [X_BITS-1:0]    x;
	logic [Y_BITS-1:0]    y;
	logic [KEY_BITS-1:0]  key;
	logic [STAT_BITS-1:0] stat;
	logic [CNT_BITS-1:0]  size;
} heap_result_t;

class heap_scoreboard;
	logic [KEY_BITS-1:0]  slot_key [HEAP_DEPTH];
	logic [CELL_BITS-1:0] slot_cell [HEAP_DEPTH];
	int                   slot_of [CELL_COUNT];
	bit                   in_heap [CELL_COUNT];
	int                   count;
	heap_result_t         pending[$];
	int                   errors;

	function new();
		count = 0;
		errors = 0;
		foreach (in_heap[i]) in_heap[i] = 1'b0;
	endfunction

	function void swap_slots(int a, int b);
		logic [KEY_BITS-1:0]  k;
		logic [CELL_BITS-1:0] c;
		k = slot_key[a];
		c = slot_cell[a];
		slot_key[a] = slot_key[b];
		slot_cell[a] = slot_cell[b];
		slot_key[b] = k;
		slot_cell[b] = c;
		slot_of[slot_cell[a]] = a;
		slot_of[slot_cell[b]] = b;
	endfunction

	function void climb(int pos);
		int parent;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!(slot_key[parent] > slot_key[pos]))
				break;
			swap_slots(pos, parent);
			pos = parent;
		end
	endfunction

	function void descend(int i);
		int l, r, best;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			best = i;
			if (l < count && slot_key[i] > slot_key[l])
				best = l;
			if (r < count && slot_key[best] > slot_key[r])
				best = r;
			if (best == i)
				break;
			swap_slots(i, best);
			i = best;
		end
	endfunction

	// work out the result of one accepted command and queue it
	function void note_command(logic op, logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y,
			logic [KEY_BITS-1:0] key);
		heap_result_t         res;
		logic [CELL_BITS-1:0] loc;
		int                   last;
		res = '{x: '0, y: '0, key: '0, stat: ST_DONE, size: '0};
		if (op == OP_INSERT) begin
			loc = {x, y};
			if (in_heap[loc]) begin
				slot_key[slot_of[loc]] = key;
				climb(slot_of[loc]);
				res.stat = ST_PRESENT;
			end else if (count < HEAP_DEPTH) begin
				slot_key[count] = key;
				slot_cell[count] = loc;
				slot_of[loc] = count;
				in_heap[loc] = 1'b1;
				count++;
				climb(count - 1);
			end
		end else if (count == 0) begin
			res.stat = ST_EMPTY;
		end else begin
			last = count - 1;
			swap_slots(0, last);
			loc = slot_cell[last];
			res.key = slot_key[last];
			count = last;
			descend(0);
			in_heap[loc] = 1'b0;
			res.x = loc[CELL_BITS-1:Y_BITS];
			res.y = loc[Y_BITS-1:0];
		end
		res.size = CNT_BITS'(count);
		pending = {pending, res};
	endfunction

	function void check_result(heap_result_t got);
		heap_result_t want;
		if (pending.size() == 0) begin
			$error("result with nothing outstanding");
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.x !== want.x) begin
			$error("out_x expected %0d got %0d", want.x, got.x);
			errors++;
		end
		if (got.y !== want.y) begin
			$error("out_y expected %0d got %0d", want.y, got.y);
			errors++;
		end
		if (got.key !== want.key) begin
			$error("out_key expected %0h got %0h", want.key, got.key);
			errors++;
		end
		if (got.stat !== want.stat) begin
			$error("status expected %0d got %0d", want.stat, got.stat);
			errors++;
		end
		if (got.size !== want.size) begin
			$error("heap_size expected %0d got %0d", want.size, got.size);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1700;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 operation;
	logic [X_BITS-1:0]    cell_x;
	logic [Y_BITS-1:0]    cell_y;
	logic [KEY_BITS-1:0]  new_key;
	logic                 done;
	logic [X_BITS-1:0]    out_x;
	logic [Y_BITS-1:0]    out_y;
	logic [KEY_BITS-1:0]  out_key;
	logic [STAT_BITS-1:0] status;
	logic [CNT_BITS-1:0]  heap_size;

	heap_scoreboard sb;
	int             quiet_cycles;
	bit             timed_out;

	indexed_min_heap_open_list_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.new_key(new_key),
		.done(done),
		.out_x(out_x),
		.out_y(out_y),
		.out_key(out_key),
		.status(status),
		.heap_size(heap_size)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// results and the watchdog, both on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result('{x: out_x, y: out_y, key: out_key, stat: status,
					size: heap_size});
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("indexed_min_heap_open_list_core regression: fail");
			$finish;
		end
	end

	// one command: present it at a falling edge, hold until the transfer
	task automatic send_cmd(logic op, logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y,
			logic [KEY_BITS-1:0] key);
		bit taken;
		taken = 1'b0;
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		cell_x <= x;
		cell_y <= y;
		new_key <= key;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1'b1;
				sb.note_command(op, x, y, key);
			end
		end
	endtask

	// idle gap with junk on the payload ports
	task automatic idle_burst(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			operation <= 1'($urandom_range(0, 1));
			cell_x <= X_BITS'($urandom);
			cell_y <= Y_BITS'($urandom);
			new_key <= $urandom;
		end
	endtask

	task automatic random_cmd(int insert_pct, bit allow_idle);
		logic [KEY_BITS-1:0] key;
		logic [X_BITS-1:0]   x;
		logic [Y_BITS-1:0]   y;
		int                  pick;
		if (allow_idle && $urandom_range(0, 3) == 0)
			idle_burst($urandom_range(1, 7));
		// a small pool of cells makes decrease-key common
		if ($urandom_range(0, 9) < 4) begin
			x = X_BITS'($urandom_range(0, 3));
			y = Y_BITS'($urandom_range(0, 3));
		end else begin
			x = X_BITS'($urandom);
			y = Y_BITS'($urandom);
		end
		pick = $urandom_range(0, 9);
		if (pick == 0)
			key = '0;
		else if (pick == 1)
			key = '1;
		else if (pick < 5)
			key = KEY_BITS'($urandom_range(0, 15));
		else
			key = $urandom;
		send_cmd($urandom_range(0, 99) < insert_pct ? OP_INSERT : OP_EXTRACT, x, y, key);
	endtask

	initial begin
		int n;
		sb = new();
		timed_out = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_INSERT;
		cell_x = '0;
		cell_y = '0;
		new_key = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed corners
		send_cmd(OP_EXTRACT, 6'd5, 6'd9, 32'h1234);
		send_cmd(OP_INSERT, 6'd0, 6'd0, 32'h0);
		send_cmd(OP_INSERT, 6'd63, 6'd63, 32'hFFFF_FFFF);
		send_cmd(OP_INSERT, 6'd1, 6'd2, 32'd50);
		send_cmd(OP_INSERT, 6'd2, 6'd1, 32'd50);
		send_cmd(OP_INSERT, 6'd3, 6'd3, 32'd50);
		send_cmd(OP_INSERT, 6'd63, 6'd63, 32'd7);
		send_cmd(OP_INSERT, 6'd1, 6'd2, 32'd900);
		send_cmd(OP_INSERT, 6'd2, 6'd1, 32'd50);
		send_cmd(OP_INSERT, 6'd0, 6'd0, 32'hFFFF_FFFF);
		send_cmd(OP_INSERT, 6'd42, 6'd21, 32'hAAAA_5555);
		send_cmd(OP_INSERT, 6'd21, 6'd42, 32'h5555_AAAA);
		repeat (9) send_cmd(OP_EXTRACT, '0, '0, '0);
		send_cmd(OP_EXTRACT, 6'd63, 6'd63, 32'hFFFF_FFFF);

		// random traffic: grow, drain and mixed phases; no gaps at the end
		n = 0;
		while (n < RANDOM_ITEMS) begin
			int phase_len, pct;
			phase_len = $urandom_range(40, 200);
			case ($urandom_range(0, 2))
				0: pct = 85;
				1: pct = 20;
				default: pct = 55;
			endcase
			repeat (phase_len) begin
				random_cmd(pct, n < RANDOM_ITEMS - 200);
				n++;
			end
		end
		@(negedge clk);
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("indexed_min_heap_open_list_core regression: pass");
		else
			$display("indexed_min_heap_open_list_core regression: fail");
		$finish;
	end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/imhol_pkg.sv
hw/rtl/indexed_min_heap_open_list_core.sv
hw/rtl/imhol_checker.sv
test/tb.sv
